// ===== rtl/core/ple_pkg.sv =====
package ple_pkg;

    // list size and derived widths
    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // fixed field widths
    localparam int FUNC_W   = 3;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 8;
    localparam int STAT_W   = 2;
    localparam int OCC_W    = 5;

    // operation codes
    typedef enum logic [FUNC_W-1:0] {
        FN_INS_FRONT = 3'd0,
        FN_INS_BACK  = 3'd1,
        FN_INS_POS   = 3'd2,
        FN_DEL_FRONT = 3'd3,
        FN_DEL_BACK  = 3'd4,
        FN_DEL_POS   = 3'd5,
        FN_TRAVERSE  = 3'd6
    } func_t;

    // result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2,
        ST_EMPTY  = 2'd3
    } status_t;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_UP,
        S_PUT,
        S_DN,
        S_WALK
    } state_t;

endpackage

// ===== rtl/core/ple_ram.sv =====
// simple dual-port storage, registered read
module ple_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/positional_list_engine_top.sv =====
// Ordered list of up to CAPACITY signed 32-bit values held in a small RAM with
// one write and one registered read port. A request is taken when start is
// high and busy is low; every result appears for one cycle with strobe high
// and cannot be held off, so the receiver must take it on that cycle. Rejected
// requests, unknown codes and deleting the last entry answer in the cycle after
// the request. An insert moves entries in S_UP and then writes the new value in
// S_PUT before it answers; a delete moves entries in S_DN. Each moved entry is
// read and written back one slot over. Traverse of n elements gives n results on
// n consecutive cycles through the RAM output register and element_reg, the
// final one marked by last. busy stays high while entries are moved or read out.
module positional_list_engine_top
    import ple_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [FUNC_W-1:0]        func,
    input  logic signed [DATA_W-1:0] value,
    input  logic [POS_W-1:0]         position,
    output logic                     strobe,
    output logic signed [DATA_W-1:0] element,
    output logic [STAT_W-1:0]        status,
    output logic [OCC_W-1:0]         occupancy,
    output logic                     last
);

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    ptr_reg, ptr_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [DATA_W-1:0]   val_reg, val_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                strobe_reg, strobe_next;
    logic [DATA_W-1:0]   element_reg, element_next;
    status_t             status_reg, status_next;
    logic                last_reg, last_next;

    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    logic [DATA_W-1:0]   mem_wdata;
    logic [IDX_W-1:0]    mem_raddr;
    logic [DATA_W-1:0]   mem_rdata;

    func_t               fn;
    logic [CNT_W-1:0]    ins_idx;
    logic [CNT_W-1:0]    del_idx;
    logic                ins_bad;
    logic                del_bad;

    // entry storage
    ple_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (DATA_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // request decode
    assign fn      = func_t'(func);
    assign ins_bad = (position == '0) ||
                     ({1'b0, position} > (9'(count_reg) + 9'd1));
    assign del_bad = (position == '0) || ({1'b0, position} > 9'(count_reg));

    always_comb
    begin
        unique case (fn)
            FN_INS_FRONT: ins_idx = '0;
            FN_INS_BACK:  ins_idx = count_reg;
            default:      ins_idx = CNT_W'(position - 8'd1);
        endcase
        unique case (fn)
            FN_DEL_FRONT: del_idx = '0;
            FN_DEL_BACK:  del_idx = count_reg - 1'b1;
            default:      del_idx = CNT_W'(position - 8'd1);
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            strobe_reg <= strobe_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        ptr_reg     <= ptr_next;
        idx_reg     <= idx_next;
        val_reg     <= val_next;
        element_reg <= element_next;
        status_reg  <= status_next;
        last_reg    <= last_next;
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        ptr_next     = ptr_reg;
        idx_next     = idx_reg;
        val_next     = val_reg;
        count_next   = count_reg;
        strobe_next  = 1'b0;
        element_next = '0;
        status_next  = ST_OK;
        last_next    = 1'b1;
        mem_we       = 1'b0;
        mem_waddr    = '0;
        mem_wdata    = '0;
        mem_raddr    = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (fn)
                        FN_INS_FRONT, FN_INS_BACK, FN_INS_POS:
                        begin
                            if (count_reg == CNT_W'(CAPACITY))
                            begin
                                strobe_next = 1'b1;
                                status_next = ST_FULL;
                            end
                            else if (fn == FN_INS_POS && ins_bad)
                            begin
                                strobe_next = 1'b1;
                                status_next = ST_BADPOS;
                            end
                            else
                            begin
                                idx_next = IDX_W'(ins_idx);
                                val_next = value;
                                if (ins_idx < count_reg)
                                begin
                                    // open a gap from the tail downwards
                                    mem_raddr  = IDX_W'(count_reg - 1'b1);
                                    ptr_next   = IDX_W'(count_reg);
                                    state_next = S_UP;
                                end
                                else
                                begin
                                    state_next = S_PUT;
                                end
                            end
                        end
                        FN_DEL_FRONT, FN_DEL_BACK, FN_DEL_POS:
                        begin
                            if (count_reg == '0)
                            begin
                                strobe_next = 1'b1;
                                status_next = ST_EMPTY;
                            end
                            else if (fn == FN_DEL_POS && del_bad)
                            begin
                                strobe_next = 1'b1;
                                status_next = ST_BADPOS;
                            end
                            else if ((del_idx + 1'b1) < count_reg)
                            begin
                                // close the gap from the hole upwards
                                mem_raddr  = IDX_W'(del_idx + 1'b1);
                                ptr_next   = IDX_W'(del_idx);
                                state_next = S_DN;
                            end
                            else
                            begin
                                count_next  = count_reg - 1'b1;
                                strobe_next = 1'b1;
                            end
                        end
                        FN_TRAVERSE:
                        begin
                            if (count_reg == '0)
                            begin
                                strobe_next = 1'b1;
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                mem_raddr  = '0;
                                ptr_next   = '0;
                                state_next = S_WALK;
                            end
                        end
                        default:
                        begin
                            strobe_next = 1'b1;
                        end
                    endcase
                end
            end
            S_UP:
            begin
                // move one entry up a slot
                mem_we    = 1'b1;
                mem_waddr = ptr_reg;
                mem_wdata = mem_rdata;
                if ((ptr_reg - 1'b1) > idx_reg)
                begin
                    mem_raddr = ptr_reg - IDX_W'(2);
                    ptr_next  = ptr_reg - 1'b1;
                end
                else
                begin
                    state_next = S_PUT;
                end
            end
            S_PUT:
            begin
                mem_we      = 1'b1;
                mem_waddr   = idx_reg;
                mem_wdata   = val_reg;
                count_next  = count_reg + 1'b1;
                strobe_next = 1'b1;
                state_next  = S_IDLE;
            end
            S_DN:
            begin
                // move one entry down a slot
                mem_we    = 1'b1;
                mem_waddr = ptr_reg;
                mem_wdata = mem_rdata;
                if ((CNT_W'(ptr_reg) + CNT_W'(2)) < count_reg)
                begin
                    mem_raddr = ptr_reg + IDX_W'(2);
                    ptr_next  = ptr_reg + 1'b1;
                end
                else
                begin
                    count_next  = count_reg - 1'b1;
                    strobe_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_WALK:
            begin
                // one element out per cycle, next read issued alongside
                strobe_next  = 1'b1;
                element_next = mem_rdata;
                last_next    = (CNT_W'(ptr_reg) + 1'b1) == count_reg;
                mem_raddr    = ptr_reg + 1'b1;
                ptr_next     = ptr_reg + 1'b1;
                if (last_next)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs
    assign busy      = (state_reg != S_IDLE);
    assign strobe    = strobe_reg;
    assign element   = element_reg;
    assign status    = status_reg;
    assign occupancy = OCC_W'(count_reg);
    assign last      = last_reg;

endmodule

// ===== rtl/core/ple_checker.sv =====
module ple_checker
    import ple_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     start,
    input logic                     busy,
    input logic                     strobe,
    input logic signed [DATA_W-1:0] element,
    input logic [STAT_W-1:0]        status,
    input logic [OCC_W-1:0]         occupancy,
    input logic                     last
);

    // occupancy never beyond the list size when a result is given
    assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (occupancy <= OCC_W'(CAPACITY)))
        else $error("occupancy above capacity");

    // a failed request gives a single result with no element
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && status != ST_OK) |-> (last && element == '0))
        else $error("failed request result malformed");

    // traverse results come back to back until the last one
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !last) |=> strobe)
        else $error("gap inside traverse");

    // busy only rises after a request was taken
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy without request");

    // occupancy steady through a traverse
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !last) |=> (occupancy == $past(occupancy)))
        else $error("occupancy changed during traverse");

endmodule

bind positional_list_engine_top ple_checker u_ple_checker (.*);
